/* rtl/core/mnseq_pkg.sv */
// melody note sequencer package: field widths, item kinds, register indexes
// and sizing of the shared serial divider
// no dependencies
package mnseq_pkg;

	// note memory geometry (depth is a power of two, addresses wrap)
	localparam int NOTE_DEPTH = 1024;
	localparam int NOTE_AW    = $clog2(NOTE_DEPTH);

	// field widths
	localparam int ADDR_W  = 10;
	localparam int WORD_W  = 16;
	localparam int TEMPO_W = 8;
	localparam int REM_W   = 18;
	localparam int DUTY_W  = 15;

	// one minute in ms, the numerator of the beat length
	localparam int MS_PER_MIN = 60 * 1000;
	// a whole note lasts four beats
	localparam int BEATS_WHOLE_LOG2 = 2;

	// serial divider: dividend and quotient share one width
	localparam int DIV_N     = REM_W;
	localparam int DIV_CNT_W = $clog2(DIV_N);

	// request kinds
	typedef enum logic [1:0] {
		KIND_TICK  = 2'd0,
		KIND_LOAD  = 2'd1,
		KIND_START = 2'd2,
		KIND_STOP  = 2'd3
	} kind_t;

	// configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_END_MARKER   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PAUSE_MARKER = 1'd1;

	// reset values
	localparam logic [TEMPO_W-1:0] TEMPO_RST = 8'd120;
	localparam logic [WORD_W-1:0]  PAUSE_RST = 16'd1;

endpackage

/* rtl/core/mnseq_ram.sv */
// generic single-port ram with registered read
// no dependencies
module mnseq_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one access per cycle, read data registered
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end
			rdata <= mem[addr];
		end
	end

endmodule

/* rtl/core/mnseq_div.sv */
// restoring serial divider, one quotient bit per cycle
// depends on mnseq_pkg
module mnseq_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [mnseq_pkg::DIV_N-1:0]   dividend,
	input  logic [mnseq_pkg::WORD_W-1:0]  divisor,
	output logic                          done,
	output logic [mnseq_pkg::DIV_N-1:0]   quotient
);
	import mnseq_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [WORD_W-1:0]    dvs_q;
	logic [WORD_W-1:0]    rem_q;
	logic [DIV_N-1:0]     quo_q;

	logic [WORD_W:0] part;
	logic [WORD_W:0] diff;
	logic            ge;

	// trial subtract of the shifted partial remainder
	always_comb begin
		part = {rem_q, quo_q[DIV_N-1]};
		diff = part - {1'b0, dvs_q};
		ge   = (part >= {1'b0, dvs_q});
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_N - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			dvs_q <= divisor;
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? diff[WORD_W-1:0] : part[WORD_W-1:0];
			quo_q <= {quo_q[DIV_N-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

/* rtl/core/melody_note_sequencer.sv */
// melody note sequencer top level: request sequencer, note ram, shared divider
// depends on mnseq_pkg, mnseq_ram, mnseq_div
// a tick that fetches a note runs two 18-bit divisions on the shared divider and two
// note ram reads; a start reads the tempo word from the note ram
// a new request is taken only once the result of the last one is registered
// reset: asynchronous, clears control state; note ram is undefined until loaded
module melody_note_sequencer (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  mnseq_pkg::kind_t                 kind,
	input  logic [mnseq_pkg::ADDR_W-1:0]     address,
	input  logic [mnseq_pkg::WORD_W-1:0]     word,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [mnseq_pkg::WORD_W-1:0]     pwm_period,
	output logic [mnseq_pkg::DUTY_W-1:0]     pwm_duty,
	output logic                             counter_on,
	output logic                             playing,
	output logic                             error,
	input  logic                             cfg_we,
	input  logic [mnseq_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mnseq_pkg::WORD_W-1:0]     cfg_data
);
	import mnseq_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_TMP_RD,
		ST_TMP_CHK,
		ST_LEN_RD,
		ST_LEN_CHK,
		ST_DIV1,
		ST_DIV2,
		ST_PER_RD,
		ST_PER_CHK,
		ST_DONE
	} state_t;

	state_t state_q;

	// configuration
	logic [WORD_W-1:0] end_mark_q;
	logic [WORD_W-1:0] pause_mark_q;

	// playback state
	logic [NOTE_AW-1:0] ptr_q;
	logic [TEMPO_W-1:0] tempo_q;
	logic [REM_W-1:0]   rem_q;
	logic [WORD_W-1:0]  len_q;
	logic               play_q;
	logic [WORD_W-1:0]  period_q;
	logic [DUTY_W-1:0]  duty_q;
	logic               cnt_on_q;
	logic               err_q;

	// result register
	logic               out_valid_q;
	logic [WORD_W-1:0]  out_period_q;
	logic [DUTY_W-1:0]  out_duty_q;
	logic               out_cnt_q;
	logic               out_play_q;
	logic               out_err_q;

	// ram and divider hookup
	logic               ram_en;
	logic               ram_we;
	logic [NOTE_AW-1:0] ram_addr;
	logic [WORD_W-1:0]  ram_rdata;
	logic               div_start;
	logic [DIV_N-1:0]   div_dividend;
	logic [WORD_W-1:0]  div_divisor;
	logic               div_done;
	logic [DIV_N-1:0]   div_quo;

	logic               in_take;
	logic [REM_W-1:0]   rem_dec;
	logic               out_free;

	assign in_ready = (state_q == ST_IDLE);
	assign in_take  = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign rem_dec  = (rem_q != '0) ? rem_q - 1'b1 : rem_q;

	// note ram port: load writes in idle, reads in the read states
	always_comb begin
		ram_we   = in_take && (kind == KIND_LOAD);
		ram_addr = ram_we ? NOTE_AW'(address) : ptr_q;
		ram_en   = ram_we || (state_q == ST_TMP_RD) || (state_q == ST_LEN_RD)
			|| (state_q == ST_PER_RD);
	end

	// divider requests: beat length first, then note length
	always_comb begin
		div_start    = 1'b0;
		div_dividend = DIV_N'(MS_PER_MIN);
		div_divisor  = WORD_W'(tempo_q);
		case (state_q)
			ST_LEN_CHK: begin
				div_start = (ram_rdata != end_mark_q) && (ram_rdata != '0)
					&& (tempo_q != '0);
			end
			ST_DIV1: begin
				div_start    = div_done;
				div_dividend = {div_quo[DIV_N-BEATS_WHOLE_LOG2-1:0],
					{BEATS_WHOLE_LOG2{1'b0}}};
				div_divisor  = len_q;
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	mnseq_ram #(
		.WIDTH(WORD_W),
		.DEPTH(NOTE_DEPTH)
	) u_ram (
		.clk   (clk),
		.en    (ram_en),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (word),
		.rdata (ram_rdata)
	);

	mnseq_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			end_mark_q   <= '0;
			pause_mark_q <= PAUSE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_END_MARKER:   end_mark_q   <= cfg_data;
				CFG_PAUSE_MARKER: pause_mark_q <= cfg_data;
				default:          end_mark_q   <= end_mark_q;
			endcase
		end
	end

	// request sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			ptr_q        <= '0;
			tempo_q      <= TEMPO_RST;
			rem_q        <= '0;
			len_q        <= '0;
			play_q       <= 1'b0;
			period_q     <= '0;
			duty_q       <= '0;
			cnt_on_q     <= 1'b0;
			err_q        <= 1'b0;
			out_valid_q  <= 1'b0;
			out_period_q <= '0;
			out_duty_q   <= '0;
			out_cnt_q    <= 1'b0;
			out_play_q   <= 1'b0;
			out_err_q    <= 1'b0;
		end else begin
			// result taken downstream, unless a new one replaces it
			if (out_valid_q && out_ready && (state_q != ST_DONE)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						case (kind)
							KIND_TICK: begin
								if (play_q) begin
									rem_q <= rem_dec;
								end else begin
									cnt_on_q <= 1'b0;
								end
								if (play_q && (rem_dec == '0)) begin
									ptr_q   <= ptr_q + 1'b1;
									state_q <= ST_LEN_RD;
								end else begin
									state_q <= ST_DONE;
								end
							end
							KIND_START: begin
								ptr_q   <= NOTE_AW'(address);
								state_q <= ST_TMP_RD;
							end
							KIND_STOP: begin
								play_q   <= 1'b0;
								cnt_on_q <= 1'b0;
								state_q  <= ST_DONE;
							end
							default: begin
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_TMP_RD: begin
					state_q <= ST_TMP_CHK;
				end
				// tempo word read, start or refuse playback
				ST_TMP_CHK: begin
					tempo_q <= ram_rdata[TEMPO_W-1:0];
					rem_q   <= '0;
					if (ram_rdata[TEMPO_W-1:0] == '0) begin
						play_q   <= 1'b0;
						cnt_on_q <= 1'b0;
						err_q    <= 1'b1;
					end else begin
						play_q <= 1'b1;
						err_q  <= 1'b0;
					end
					state_q <= ST_DONE;
				end
				ST_LEN_RD: begin
					state_q <= ST_LEN_CHK;
				end
				// length word: end of song, bad length, or divide
				ST_LEN_CHK: begin
					len_q <= ram_rdata;
					if (ram_rdata == end_mark_q) begin
						play_q   <= 1'b0;
						cnt_on_q <= 1'b0;
						state_q  <= ST_DONE;
					end else if (ram_rdata == '0 || tempo_q == '0) begin
						play_q   <= 1'b0;
						cnt_on_q <= 1'b0;
						err_q    <= 1'b1;
						state_q  <= ST_DONE;
					end else begin
						state_q <= ST_DIV1;
					end
				end
				ST_DIV1: begin
					if (div_done) begin
						state_q <= ST_DIV2;
					end
				end
				ST_DIV2: begin
					if (div_done) begin
						rem_q   <= div_quo;
						ptr_q   <= ptr_q + 1'b1;
						state_q <= ST_PER_RD;
					end
				end
				ST_PER_RD: begin
					state_q <= ST_PER_CHK;
				end
				// period word sets the tone
				ST_PER_CHK: begin
					period_q <= ram_rdata;
					duty_q   <= (ram_rdata == pause_mark_q) ? '0 : ram_rdata[WORD_W-1:1];
					cnt_on_q <= 1'b1;
					state_q  <= ST_DONE;
				end
				// hand the state to the result register
				ST_DONE: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_period_q <= period_q;
						out_duty_q   <= duty_q;
						out_cnt_q    <= cnt_on_q;
						out_play_q   <= play_q;
						out_err_q    <= err_q;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign pwm_period = out_period_q;
	assign pwm_duty   = out_duty_q;
	assign counter_on = out_cnt_q;
	assign playing    = out_play_q;
	assign error      = out_err_q;

endmodule

/* rtl/core/mnseq_checker.sv */
// port-level checks for the melody note sequencer, bound to the top level
// depends on mnseq_pkg and melody_note_sequencer
module mnseq_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	input  logic                             in_ready,
	input  logic                             out_valid,
	input  logic                             out_ready,
	input  logic [mnseq_pkg::WORD_W-1:0]     pwm_period,
	input  logic [mnseq_pkg::DUTY_W-1:0]     pwm_duty,
	input  logic                             counter_on,
	input  logic                             playing,
	input  logic                             error
);
	import mnseq_pkg::*;

	// a stopped-on-error song is never reported as playing
	a_err_not_play: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(error && playing))
		else $error("error and playing both set");

	// the tone counter only runs during a song
	a_cnt_needs_play: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && counter_on |-> playing)
		else $error("counter on without playback");

	// duty is zero or half the period
	a_duty_half: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pwm_duty == '0) || (pwm_duty == pwm_period[WORD_W-1:1]))
		else $error("duty not half the period");

	// a taken request drops ready in the following cycle
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready right after a request");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pwm_period)
			&& $stable(pwm_duty) && $stable(counter_on) && $stable(playing)
			&& $stable(error))
		else $error("stalled result changed");

endmodule

bind melody_note_sequencer mnseq_checker u_mnseq_checker (.*);
